[rtl/rir_pkg.sv]
package rir_pkg;

  localparam int ID_W              = 62;
  localparam int ACT_W             = 3;
  localparam int ST_W              = 2;
  localparam int EC_W              = 2;

  localparam int DEF_LOCAL_ENTRIES = 16;
  localparam int DEF_PEER_ENTRIES  = 16;
  localparam int DEF_ID_BITS       = 62;

  localparam logic [ACT_W-1:0] ACT_ALLOC     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_VALIDATE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REG_LOCAL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNREG     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REG_PEER  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET     = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_PARITY = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  localparam logic [EC_W-1:0] EC_NONE     = 2'd0;
  localparam logic [EC_W-1:0] EC_INVALID  = 2'd1;
  localparam logic [EC_W-1:0] EC_INTERNAL = 2'd2;

  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

  function automatic logic [EC_W-1:0] class_of(input logic [ST_W-1:0] st);
    logic [EC_W-1:0] ec;
    case (st)
      ST_OK:     ec = EC_NONE;
      ST_PARITY: ec = EC_INVALID;
      ST_DUP:    ec = EC_INVALID;
      ST_FULL:   ec = EC_INTERNAL;
      default:   ec = EC_NONE;
    endcase
    return ec;
  endfunction

endpackage

[rtl/rir_ram.sv]
module rir_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/rir_unit.sv]
module rir_unit #(
  parameter int ID_BITS = 62
) (
  input  logic [ID_BITS-1:0] a,
  input  logic [ID_BITS-1:0] b,
  output rir_pkg::cmp_res_t  res,
  output logic [ID_BITS-1:0] sum
);
  import rir_pkg::*;

  localparam logic [ID_BITS-1:0] STEP = ID_BITS'(2);

  assign res.eq = (a == b);
  assign res.ge = (a >= b);
  assign sum    = a + STEP;

endmodule

[rtl/request_id_registry.sv]
// Request ID registry. One word in on start (accepted while busy is low), one
// result word out, shown for a single cycle with out_valid; the receiver
// cannot stall it. Validate, register local, unregister and register peer
// walk the chosen table one entry per cycle through its RAM read port and a
// shared comparator, and a new word is accepted only once the walk and the
// result are done. Allocate, reset, unused action codes and parity failures
// skip the walk. cfg_data sets the role bit (1 = server, odd local IDs); the
// user must write it only while idle, which the block itself does not enforce.
module request_id_registry #(
  parameter int LOCAL_ENTRIES = rir_pkg::DEF_LOCAL_ENTRIES,
  parameter int PEER_ENTRIES  = rir_pkg::DEF_PEER_ENTRIES,
  parameter int ID_BITS       = rir_pkg::DEF_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [rir_pkg::ACT_W-1:0] in_action,
  input  logic [rir_pkg::ID_W-1:0]  in_request_id,
  output logic                      out_valid,
  output logic [rir_pkg::ST_W-1:0]  out_status,
  output logic [rir_pkg::EC_W-1:0]  out_error_class,
  output logic [rir_pkg::ID_W-1:0]  out_allocated_id
);
  import rir_pkg::*;

  localparam int LIW = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
  localparam int PIW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
  localparam int SIW = (LIW > PIW) ? LIW : PIW;
  localparam logic [SIW-1:0] LOC_LAST  = SIW'(LOCAL_ENTRIES - 1);
  localparam logic [SIW-1:0] PEER_LAST = SIW'(PEER_ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic                     lis_r;
  logic [ACT_W-1:0]         act_r;
  logic [ID_BITS-1:0]       id_r;
  logic                     tbl_peer_r;
  logic [SIW-1:0]           idx_r;
  logic [SIW-1:0]           cmp_idx_r;
  logic                     cmp_vld_r;
  logic                     found_r;
  logic [SIW-1:0]           match_idx_r;
  logic                     free_found_r;
  logic [SIW-1:0]           free_idx_r;
  logic [ID_BITS-1:0]       next_local_r, next_local_nxt;
  logic [LOCAL_ENTRIES-1:0] loc_valid_r, loc_valid_nxt;
  logic [PEER_ENTRIES-1:0]  peer_valid_r, peer_valid_nxt;

  logic [63:0]              req_ext;
  logic [ID_BITS-1:0]       id_in;
  logic                     accept;
  logic                     in_par_bad;
  logic                     need_scan;
  logic [ID_BITS-1:0]       loc_rdata, peer_rdata;
  logic [ID_BITS-1:0]       unit_a, unit_b, unit_sum;
  cmp_res_t                 unit_res;
  logic                     vbit;
  logic                     last_issue;
  logic                     par_bad_loc, par_bad_peer;
  logic [ST_W-1:0]          st;
  logic [ID_BITS-1:0]       alloc;
  logic                     ins_loc, ins_peer;
  logic [63:0]              alloc_ext;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign req_ext = 64'(in_request_id);
  assign id_in   = req_ext[ID_BITS-1:0];

  always_comb begin
    in_par_bad = 1'b0;
    if (in_action inside {ACT_VALIDATE, ACT_REG_LOCAL}) begin
      in_par_bad = (id_in[0] != lis_r);
    end else if (in_action == ACT_REG_PEER) begin
      in_par_bad = (id_in[0] == lis_r);
    end
    need_scan = (in_action inside {ACT_VALIDATE, ACT_REG_LOCAL, ACT_UNREG, ACT_REG_PEER})
                && !in_par_bad;
  end

  rir_ram #(.WIDTH(ID_BITS), .DEPTH(LOCAL_ENTRIES)) u_loc_ram (
    .clk   (clk),
    .we    (ins_loc),
    .waddr (free_idx_r[LIW-1:0]),
    .wdata (id_r),
    .raddr (idx_r[LIW-1:0]),
    .rdata (loc_rdata)
  );

  rir_ram #(.WIDTH(ID_BITS), .DEPTH(PEER_ENTRIES)) u_peer_ram (
    .clk   (clk),
    .we    (ins_peer),
    .waddr (free_idx_r[PIW-1:0]),
    .wdata (id_r),
    .raddr (idx_r[PIW-1:0]),
    .rdata (peer_rdata)
  );

  assign unit_a = (state_r == S_FIN && act_r == ACT_ALLOC) ? next_local_r : id_r;
  assign unit_b = (state_r == S_FIN) ? next_local_r : (tbl_peer_r ? peer_rdata : loc_rdata);

  rir_unit #(.ID_BITS(ID_BITS)) u_unit (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res),
    .sum (unit_sum)
  );

  assign vbit = tbl_peer_r ? peer_valid_r[cmp_idx_r[PIW-1:0]]
                           : loc_valid_r[cmp_idx_r[LIW-1:0]];
  assign last_issue = (idx_r == (tbl_peer_r ? PEER_LAST : LOC_LAST));

  assign par_bad_loc  = (id_r[0] != lis_r);
  assign par_bad_peer = (id_r[0] == lis_r);

  always_comb begin
    st             = ST_OK;
    alloc          = '0;
    ins_loc        = 1'b0;
    ins_peer       = 1'b0;
    next_local_nxt = next_local_r;
    loc_valid_nxt  = loc_valid_r;
    peer_valid_nxt = peer_valid_r;
    if (state_r == S_FIN) begin
      case (act_r)
        ACT_ALLOC: begin
          alloc          = next_local_r;
          next_local_nxt = unit_sum;
        end
        ACT_VALIDATE: begin
          st = par_bad_loc ? ST_PARITY : (found_r ? ST_DUP : ST_OK);
        end
        ACT_REG_LOCAL: begin
          if (par_bad_loc) begin
            st = ST_PARITY;
          end else if (found_r) begin
            st = ST_DUP;
          end else if (!free_found_r) begin
            st = ST_FULL;
          end else begin
            ins_loc = 1'b1;
            loc_valid_nxt[free_idx_r[LIW-1:0]] = 1'b1;
            if (unit_res.ge) begin
              next_local_nxt = unit_sum;
            end
          end
        end
        ACT_UNREG: begin
          if (found_r) begin
            loc_valid_nxt[match_idx_r[LIW-1:0]] = 1'b0;
          end else begin
            st = ST_DUP;
          end
        end
        ACT_REG_PEER: begin
          if (par_bad_peer) begin
            st = ST_PARITY;
          end else if (found_r) begin
            st = ST_DUP;
          end else if (!free_found_r) begin
            st = ST_FULL;
          end else begin
            ins_peer = 1'b1;
            peer_valid_nxt[free_idx_r[PIW-1:0]] = 1'b1;
          end
        end
        ACT_RESET: begin
          loc_valid_nxt  = '0;
          peer_valid_nxt = '0;
          next_local_nxt = ID_BITS'(lis_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign alloc_ext = 64'(alloc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lis_r        <= 1'b0;
      next_local_r <= '0;
      loc_valid_r  <= '0;
      peer_valid_r <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_local_r <= next_local_nxt;
      loc_valid_r  <= loc_valid_nxt;
      peer_valid_r <= peer_valid_nxt;
      cmp_vld_r    <= (state_r == S_SCAN);
      out_valid    <= (state_r == S_FIN);
      if (cfg_we) begin
        lis_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (accept) begin
      act_r        <= in_action;
      id_r         <= id_in;
      tbl_peer_r   <= (in_action == ACT_REG_PEER);
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      match_idx_r  <= '0;
      free_idx_r   <= '0;
    end else begin
      if (state_r == S_SCAN) begin
        idx_r <= idx_r + SIW'(1);
      end
      if (cmp_vld_r) begin
        if (vbit && unit_res.eq && !found_r) begin
          found_r     <= 1'b1;
          match_idx_r <= cmp_idx_r;
        end
        if (!vbit && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
      end
    end
    if (state_r == S_FIN) begin
      out_status       <= st;
      out_error_class  <= class_of(st);
      out_allocated_id <= alloc_ext[ID_W-1:0];
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_valid)
    else $error("result strobe missing after finish");

  a_strobe_only_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without finish");

  a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_class == class_of(out_status)))
    else $error("error class does not match status");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allocated_id != '0) |-> (out_status == ST_OK))
    else $error("allocated id with failing status");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rir_pkg::*;

  localparam int LOCAL_N = DEF_LOCAL_ENTRIES;
  localparam int PEER_N  = DEF_PEER_ENTRIES;
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;
  localparam logic [ID_W-1:0]  ID_MAX      = {ID_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_MAX_EVEN = ID_MAX - ID_W'(1);
  localparam int DIR_N = 22;

  typedef struct packed {
    logic [ST_W-1:0] st;
    logic [EC_W-1:0] ec;
    logic [ID_W-1:0] alloc;
  } reply_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    logic             pin;
    reply_t           res;
  } dir_row_t;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             cfg_we        = 1'b0;
  logic             cfg_data      = 1'b0;
  logic             start         = 1'b0;
  logic [ACT_W-1:0] in_action     = '0;
  logic [ID_W-1:0]  in_request_id = '0;
  logic             busy;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [EC_W-1:0]  out_error_class;
  logic [ID_W-1:0]  out_allocated_id;

  // registry shadow
  logic [ID_W-1:0] loc_ids  [LOCAL_N];
  bit              loc_vld  [LOCAL_N];
  logic [ID_W-1:0] remote_ids [PEER_N];
  bit              peer_vld [PEER_N];
  logic [ID_W-1:0] next_id = '0;
  logic            role    = 1'b0;

  reply_t replies_due [$];
  int     bad_words = 0;
  int     idle_pct  = 0;

  dir_row_t dir_rows [DIR_N] = '{
    '{ACT_ALLOC,     '0,                    1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_ALLOC,     '0,                    1'b1, '{ST_OK,     EC_NONE,    62'd2}},
    '{ACT_VALIDATE,  62'd1,                 1'b1, '{ST_PARITY, EC_INVALID, 62'd0}},
    '{ACT_VALIDATE,  62'd0,                 1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_REG_LOCAL, ID_MAX_EVEN,           1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_ALLOC,     '0,                    1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_REG_LOCAL, ID_MAX_EVEN,           1'b1, '{ST_DUP,    EC_INVALID, 62'd0}},
    '{ACT_VALIDATE,  ID_MAX_EVEN,           1'b1, '{ST_DUP,    EC_INVALID, 62'd0}},
    '{ACT_REG_LOCAL, 62'd0,                 1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_UNREG,     62'd0,                 1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_UNREG,     62'd0,                 1'b1, '{ST_DUP,    EC_INVALID, 62'd0}},
    '{ACT_UNREG,     ID_MAX,                1'b1, '{ST_DUP,    EC_INVALID, 62'd0}},
    '{ACT_REG_PEER,  62'd0,                 1'b1, '{ST_PARITY, EC_INVALID, 62'd0}},
    '{ACT_REG_PEER,  ID_MAX,                1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_REG_PEER,  ID_MAX,                1'b1, '{ST_DUP,    EC_INVALID, 62'd0}},
    '{ACT_REG_PEER,  62'd1,                 1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_SPARE_A,   62'h2AAA_AAAA_AAAA_AAAA, 1'b1, '{ST_OK,   EC_NONE,    62'd0}},
    '{ACT_SPARE_B,   62'h1555_5555_5555_5555, 1'b1, '{ST_OK,   EC_NONE,    62'd0}},
    '{ACT_REG_LOCAL, 62'h1555_5555_5555_5554, 1'b0, '0},
    '{ACT_ALLOC,     '0,                    1'b0, '0},
    '{ACT_RESET,     '0,                    1'b1, '{ST_OK,     EC_NONE,    62'd0}},
    '{ACT_ALLOC,     '0,                    1'b1, '{ST_OK,     EC_NONE,    62'd0}}
  };

  request_id_registry u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_request_id    (in_request_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_error_class  (out_error_class),
    .out_allocated_id (out_allocated_id)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int find_slot(input bit peer, input logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < (peer ? PEER_N : LOCAL_N); i++) begin
      if (peer ? (peer_vld[i] && remote_ids[i] == id) : (loc_vld[i] && loc_ids[i] == id))
        return i;
    end
    return -1;
  endfunction

  function automatic int first_free(input bit peer);
    int i;
    for (i = 0; i < (peer ? PEER_N : LOCAL_N); i++) begin
      if (!(peer ? peer_vld[i] : loc_vld[i]))
        return i;
    end
    return -1;
  endfunction

  function automatic reply_t registry_apply(input logic [ACT_W-1:0] act,
                                            input logic [ID_W-1:0] id);
    reply_t r;
    int     slot;
    int     i;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        r.alloc = next_id;
        next_id = next_id + ID_W'(2);
      end
      ACT_VALIDATE, ACT_REG_LOCAL: begin
        if (id[0] != role) r.st = ST_PARITY;
        else if (find_slot(1'b0, id) >= 0) r.st = ST_DUP;
        if (act == ACT_REG_LOCAL && r.st == ST_OK) begin
          slot = first_free(1'b0);
          if (slot < 0) begin
            r.st = ST_FULL;
          end else begin
            loc_ids[slot] = id;
            loc_vld[slot] = 1'b1;
            if (id >= next_id) next_id = id + ID_W'(2);
          end
        end
      end
      ACT_UNREG: begin
        slot = find_slot(1'b0, id);
        if (slot < 0) r.st = ST_DUP;
        else loc_vld[slot] = 1'b0;
      end
      ACT_REG_PEER: begin
        if (id[0] == role) begin
          r.st = ST_PARITY;
        end else if (find_slot(1'b1, id) >= 0) begin
          r.st = ST_DUP;
        end else begin
          slot = first_free(1'b1);
          if (slot < 0) begin
            r.st = ST_FULL;
          end else begin
            remote_ids[slot] = id;
            peer_vld[slot] = 1'b1;
          end
        end
      end
      ACT_RESET: begin
        for (i = 0; i < LOCAL_N; i++) loc_vld[i] = 1'b0;
        for (i = 0; i < PEER_N; i++) peer_vld[i] = 1'b0;
        next_id = {{(ID_W-1){1'b0}}, role};
      end
      default: ;
    endcase
    case (r.st)
      ST_OK:   r.ec = EC_NONE;
      ST_FULL: r.ec = EC_INTERNAL;
      default: r.ec = EC_INVALID;
    endcase
    return r;
  endfunction

  function automatic logic [ACT_W-1:0] pick_act();
    int k;
    k = $urandom_range(99);
    if (k < 12) return ACT_ALLOC;
    if (k < 26) return ACT_VALIDATE;
    if (k < 50) return ACT_REG_LOCAL;
    if (k < 70) return ACT_UNREG;
    if (k < 92) return ACT_REG_PEER;
    if (k < 96) return ACT_RESET;
    if (k < 98) return ACT_SPARE_A;
    return ACT_SPARE_B;
  endfunction

  function automatic logic [ID_W-1:0] known_id(input bit peer);
    int idx [$];
    int i;
    int k;
    for (i = 0; i < (peer ? PEER_N : LOCAL_N); i++)
      if (peer ? peer_vld[i] : loc_vld[i]) idx.push_back(i);
    if (idx.size() == 0) return next_id;
    k = idx[$urandom_range(idx.size() - 1)];
    return peer ? remote_ids[k] : loc_ids[k];
  endfunction

  function automatic logic [ID_W-1:0] pick_id(input logic [ACT_W-1:0] act);
    logic [ID_W-1:0] id;
    int              k;
    k = $urandom_range(99);
    if (k < 30) id = known_id(act == ACT_REG_PEER);
    else if (k < 50) id = next_id + ID_W'(2 * $urandom_range(3));
    else if (k < 60) id = ID_MAX - ID_W'($urandom_range(7));
    else if (k < 80) id = ID_W'($urandom_range(63));
    else id = ID_W'({$urandom, $urandom});
    if ($urandom_range(99) < 85) id[0] = (act == ACT_REG_PEER) ? !role : role;
    return id;
  endfunction

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                           input logic pin, input reply_t pinned);
    reply_t r;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_request_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = registry_apply(act, id);
    replies_due.push_back(pin ? pinned : r);
  endtask

  task automatic set_role(input logic v);
    start <= 1'b0;
    while (replies_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    role = v;
  endtask

  task automatic flag(input string what, input logic [ID_W-1:0] want,
                      input logic [ID_W-1:0] got);
    bad_words++;
    if (bad_words <= 10)
      $display("%0t: %s mismatch: want %0h got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%0t: word with nothing due: st %0d ec %0d id %0h", $time,
                   out_status, out_error_class, out_allocated_id);
      end else begin
        w = replies_due.pop_front();
        if (out_status !== w.st) flag("status", w.st, out_status);
        if (out_error_class !== w.ec) flag("error_class", w.ec, out_error_class);
        if (out_allocated_id !== w.alloc) flag("allocated_id", w.alloc, out_allocated_id);
      end
    end
  end

  initial begin
    int              ph;
    int              cnt;
    int              n;
    int              i;
    bit              peer;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    for (i = 0; i < LOCAL_N; i++) loc_vld[i] = 1'b0;
    for (i = 0; i < PEER_N; i++) peer_vld[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_N; i++)
      send_word(dir_rows[i].act, dir_rows[i].id, dir_rows[i].pin, dir_rows[i].res);

    for (ph = 0; ph < 4; ph++) begin
      set_role(ph % 2 == 0);
      idle_pct = (ph == 1) ? 52 : (ph == 3) ? 34 : 0;
      if ($urandom_range(1)) send_word(ACT_RESET, '0, 1'b0, '0);
      cnt = 0;
      while (cnt < 150) begin
        if ($urandom_range(3) == 0) begin
          // fill one table past capacity
          peer = $urandom_range(1);
          n = 16 + $urandom_range(3);
          repeat (n) begin
            id = $urandom_range(1) ? ID_W'({$urandom, $urandom}) : ID_W'($urandom_range(255));
            id[0] = peer ? !role : role;
            send_word(peer ? ACT_REG_PEER : ACT_REG_LOCAL, id, 1'b0, '0);
            cnt++;
          end
        end else begin
          n = $urandom_range(10, 30);
          repeat (n) begin
            act = pick_act();
            send_word(act, pick_id(act), 1'b0, '0);
            cnt++;
          end
        end
      end
    end

    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bad_words == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
